// ===== hw/rtl/rbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants for the ray / box picker
// Widths, sequencer states, configuration register codes and the
// divider request and status structures.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int COORD_W       = 32;
    localparam int DIR_W         = 18;
    localparam int IDX_W         = 8;
    localparam int NUM_W         = COORD_W + 1;
    localparam int Q_W           = 32;
    localparam int CNT_W         = $clog2(Q_W);
    localparam int AXES          = 3;
    localparam int AXIS_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_OBJECTS   = 256;

    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_LO,
        ST_HI,
        ST_HIT
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_ORIGIN_Z       = 3'd2,
        CFG_SELECTED_VALID = 3'd3,
        CFG_SELECTED_INDEX = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DIR_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [COORD_W-1:0] quot;
    } div_st_t;

endpackage

// ===== hw/rtl/ray_box_pick.sv =====
// ----------------------------------------------------------------------------
// ray_box_pick: ray / axis-aligned box slab test with hover picking
// Each transaction carries a ray direction and one box. The ray starts at the
// configured origin. The box is hit unless the origin lies outside a slab
// whose direction component is zero, its exit distance is behind the origin
// or its entry distance exceeds its exit distance. Over a run of boxes the
// last hit box that is not the selected object is reported on the result of
// the run's last box, after which the hover state clears. All distances are
// signed Q16.16 and saturate to 32 bits. One transaction is in work at a
// time: an axis with a zero direction component is checked without division,
// any other axis takes two distances from the shared bit-serial divider (one
// quotient bit per cycle over 32 bits), and the next box is accepted only
// after the result is loaded and the sequencer is back in idle. The result
// sits in an output register, so the next box is accepted while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module ray_box_pick #(
    parameter int FRAC_BITS = rbp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbp_pkg::COORD_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rbp_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [rbp_pkg::DIR_W-1:0]    dir_y,
    input  logic signed [rbp_pkg::DIR_W-1:0]    dir_z,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_x_min,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_x_max,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_y_min,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_y_max,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_z_min,
    input  logic signed [rbp_pkg::COORD_W-1:0]  box_z_max,
    input  logic [rbp_pkg::IDX_W-1:0]           object_index,
    input  logic                                last_box,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                hover_valid,
    output logic [rbp_pkg::IDX_W-1:0]           hover_index,
    output logic                                run_done
);

    // configuration
    logic signed [rbp_pkg::COORD_W-1:0] origin_reg [rbp_pkg::AXES];
    logic                               sel_valid_reg;
    logic [rbp_pkg::IDX_W-1:0]          sel_index_reg;

    // captured transaction
    logic signed [rbp_pkg::DIR_W-1:0]   dir_reg  [rbp_pkg::AXES];
    logic signed [rbp_pkg::COORD_W-1:0] bmin_reg [rbp_pkg::AXES];
    logic signed [rbp_pkg::COORD_W-1:0] bmax_reg [rbp_pkg::AXES];
    logic [rbp_pkg::IDX_W-1:0]          idx_reg;
    logic                               last_reg;

    // sequencer
    rbp_pkg::state_t                    state_reg, state_next;
    logic [rbp_pkg::AXIS_W-1:0]         axis_reg, axis_next;
    logic                               ok_reg, ok_next;
    logic signed [rbp_pkg::COORD_W-1:0] t1_reg, t1_next;
    logic signed [rbp_pkg::COORD_W-1:0] tmin_reg, tmin_next;
    logic signed [rbp_pkg::COORD_W-1:0] tmax_reg, tmax_next;

    // hover state
    logic                               hover_found_reg, hover_found_next;
    logic [rbp_pkg::IDX_W-1:0]          hover_obj_reg, hover_obj_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic                               hit_reg, hit_next;
    logic                               hov_valid_reg, hov_valid_next;
    logic [rbp_pkg::IDX_W-1:0]          hov_index_reg, hov_index_next;
    logic                               run_done_reg, run_done_next;

    logic                               in_accept;
    logic                               can_load;
    logic                               last_axis;
    logic signed [rbp_pkg::DIR_W-1:0]   cur_dir;
    logic signed [rbp_pkg::COORD_W-1:0] cur_b0, cur_b1, cur_o, t2;
    logic                               b0_lt_b1, o_lt_b0, o_lt_b1, o_gt_b0, o_gt_b1;
    logic                               outside;
    logic                               c12, lo_wins, hi_wins;
    logic                               hit_now, hover_take;

    rbp_pkg::div_req_t                  dreq;
    rbp_pkg::div_st_t                   dst;

    rbp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .st    (dst)
    );

    assign in_stall  = (state_reg != rbp_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign last_axis = (axis_reg == rbp_pkg::AXIS_W'(rbp_pkg::AXES - 1));

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign hover_valid = hov_valid_reg;
    assign hover_index = hov_index_reg;
    assign run_done    = run_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            sel_valid_reg <= 1'b0;
            sel_index_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (rbp_pkg::cfg_idx_t'(cfg_index))
                rbp_pkg::CFG_ORIGIN_X:       origin_reg[0] <= cfg_data;
                rbp_pkg::CFG_ORIGIN_Y:       origin_reg[1] <= cfg_data;
                rbp_pkg::CFG_ORIGIN_Z:       origin_reg[2] <= cfg_data;
                rbp_pkg::CFG_SELECTED_VALID: sel_valid_reg <= cfg_data[0];
                rbp_pkg::CFG_SELECTED_INDEX: sel_index_reg <= cfg_data[rbp_pkg::IDX_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dir_reg[0]  <= dir_x;
            dir_reg[1]  <= dir_y;
            dir_reg[2]  <= dir_z;
            bmin_reg[0] <= box_x_min;
            bmax_reg[0] <= box_x_max;
            bmin_reg[1] <= box_y_min;
            bmax_reg[1] <= box_y_max;
            bmin_reg[2] <= box_z_min;
            bmax_reg[2] <= box_z_max;
            idx_reg     <= object_index;
            last_reg    <= last_box;
        end
    end

    always_comb
    begin
        cur_dir = dir_reg[axis_reg];
        cur_b0  = bmin_reg[axis_reg];
        cur_b1  = bmax_reg[axis_reg];
        cur_o   = origin_reg[axis_reg];
        t2      = dst.quot;

        b0_lt_b1 = cur_b0 < cur_b1;
        o_lt_b0  = cur_o < cur_b0;
        o_lt_b1  = cur_o < cur_b1;
        o_gt_b0  = cur_o > cur_b0;
        o_gt_b1  = cur_o > cur_b1;
        outside  = b0_lt_b1 ? (o_lt_b0 || o_gt_b1) : (o_lt_b1 || o_gt_b0);

        c12     = t1_reg < t2;
        lo_wins = c12 ? (tmin_reg < t1_reg) : (tmin_reg < t2);
        hi_wins = c12 ? (t2 < tmax_reg) : (t1_reg < tmax_reg);

        hit_now    = ok_reg && !(tmax_reg < 0) && !(tmin_reg > tmax_reg);
        hover_take = hit_now && (int'(idx_reg) < rbp_pkg::MAX_OBJECTS) &&
                     !(sel_valid_reg && (idx_reg == sel_index_reg));

        dreq.start = 1'b0;
        dreq.num   = (state_reg == rbp_pkg::ST_AXIS)
                   ? ({cur_b0[rbp_pkg::COORD_W-1], cur_b0} - {cur_o[rbp_pkg::COORD_W-1], cur_o})
                   : ({cur_b1[rbp_pkg::COORD_W-1], cur_b1} - {cur_o[rbp_pkg::COORD_W-1], cur_o});
        dreq.den   = cur_dir;

        state_next       = state_reg;
        axis_next        = axis_reg;
        ok_next          = ok_reg;
        t1_next          = t1_reg;
        tmin_next        = tmin_reg;
        tmax_next        = tmax_reg;
        hover_found_next = hover_found_reg;
        hover_obj_next   = hover_obj_reg;
        out_valid_next   = out_valid_reg && out_stall;
        hit_next         = hit_reg;
        hov_valid_next   = hov_valid_reg;
        hov_index_next   = hov_index_reg;
        run_done_next    = run_done_reg;

        case (state_reg)
            rbp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    axis_next  = '0;
                    ok_next    = 1'b1;
                    tmin_next  = rbp_pkg::T_MIN;
                    tmax_next  = rbp_pkg::T_MAX;
                    state_next = rbp_pkg::ST_AXIS;
                end
            end
            rbp_pkg::ST_AXIS:
            begin
                if (cur_dir == '0)
                begin
                    if (outside)
                        ok_next = 1'b0;
                    axis_next  = axis_reg + 1'b1;
                    state_next = last_axis ? rbp_pkg::ST_HIT : rbp_pkg::ST_AXIS;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = rbp_pkg::ST_LO;
                end
            end
            rbp_pkg::ST_LO:
            begin
                if (dst.done)
                begin
                    t1_next    = dst.quot;
                    dreq.start = 1'b1;
                    state_next = rbp_pkg::ST_HI;
                end
            end
            rbp_pkg::ST_HI:
            begin
                if (dst.done)
                begin
                    if (lo_wins)
                        tmin_next = c12 ? t1_reg : t2;
                    if (hi_wins)
                        tmax_next = c12 ? t2 : t1_reg;
                    axis_next  = axis_reg + 1'b1;
                    state_next = last_axis ? rbp_pkg::ST_HIT : rbp_pkg::ST_AXIS;
                end
            end
            rbp_pkg::ST_HIT:
            begin
                if (can_load)
                begin
                    if (hover_take)
                    begin
                        hover_found_next = 1'b1;
                        hover_obj_next   = idx_reg;
                    end
                    out_valid_next = 1'b1;
                    hit_next       = hit_now;
                    run_done_next  = last_reg;
                    if (last_reg)
                    begin
                        hov_valid_next   = hover_found_next;
                        hov_index_next   = hover_obj_next;
                        hover_found_next = 1'b0;
                        hover_obj_next   = '0;
                    end
                    else
                    begin
                        hov_valid_next = 1'b0;
                        hov_index_next = '0;
                    end
                    state_next = rbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rbp_pkg::ST_IDLE;
            axis_reg        <= '0;
            ok_reg          <= 1'b0;
            hover_found_reg <= 1'b0;
            hover_obj_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            axis_reg        <= axis_next;
            ok_reg          <= ok_next;
            hover_found_reg <= hover_found_next;
            hover_obj_reg   <= hover_obj_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg        <= t1_next;
        tmin_reg      <= tmin_next;
        tmax_reg      <= tmax_next;
        hit_reg       <= hit_next;
        hov_valid_reg <= hov_valid_next;
        hov_index_reg <= hov_index_next;
        run_done_reg  <= run_done_next;
    end

    a_hover_only_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !run_done_reg |-> !hov_valid_reg && (hov_index_reg == '0))
        else $error("hover fields set on a result that does not end a run");

    a_div_done_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
        dst.done |-> (state_reg == rbp_pkg::ST_LO) || (state_reg == rbp_pkg::ST_HI))
        else $error("divider result arrived while the sequencer was not waiting");

    a_div_quiet_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbp_pkg::ST_IDLE) || (state_reg == rbp_pkg::ST_HIT)
            |-> !dst.busy && !dst.done)
        else $error("divider active outside of a slab computation");

    a_hover_clears_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbp_pkg::ST_HIT) && can_load && last_reg
            |=> !hover_found_reg && (hover_obj_reg == '0))
        else $error("hover state not cleared after the last box of a run");

endmodule

// ===== hw/rtl/rbp_div.sv =====
// ----------------------------------------------------------------------------
// rbp_div: shared iterative distance divider
// Computes (num * 2^FRAC_BITS) / den truncated toward zero and saturated to
// 32 bits signed, one restoring step per cycle over 32 quotient bits. The
// top step detects saturation; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module rbp_div #(
    parameter int FRAC_BITS = rbp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rbp_pkg::div_req_t req,
    output rbp_pkg::div_st_t  st
);

    localparam int MAG_W = rbp_pkg::NUM_W + FRAC_BITS;
    localparam int DSH_W = rbp_pkg::DIR_W + rbp_pkg::Q_W - 1;
    localparam int CMP_W = (MAG_W > DSH_W) ? MAG_W : DSH_W;

    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic [rbp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CMP_W-1:0]              rem_reg, rem_next;
    logic [CMP_W-1:0]              dsh_reg, dsh_next;
    logic [rbp_pkg::Q_W-1:0]       q_reg, q_next;
    logic                          neg_reg, neg_next;

    logic [rbp_pkg::NUM_W-1:0]     num_mag;
    logic [rbp_pkg::DIR_W-1:0]     den_mag;
    logic                          ge;
    logic [CMP_W-1:0]              diff;
    logic signed [rbp_pkg::COORD_W-1:0] mag;

    always_comb
    begin
        num_mag = req.num[rbp_pkg::NUM_W-1] ? rbp_pkg::NUM_W'(-req.num)
                                             : rbp_pkg::NUM_W'(req.num);
        den_mag = req.den[rbp_pkg::DIR_W-1] ? rbp_pkg::DIR_W'(-req.den)
                                             : rbp_pkg::DIR_W'(req.den);
        ge      = rem_reg >= dsh_reg;
        diff    = rem_reg - dsh_reg;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = rbp_pkg::CNT_W'(rbp_pkg::Q_W - 1);
            rem_next  = CMP_W'(num_mag) << FRAC_BITS;
            dsh_next  = CMP_W'(den_mag) << (rbp_pkg::Q_W - 1);
            q_next    = '0;
            neg_next  = req.num[rbp_pkg::NUM_W-1] ^ req.den[rbp_pkg::DIR_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[rbp_pkg::Q_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        mag     = {1'b0, q_reg[rbp_pkg::Q_W-2:0]};
        st.busy = busy_reg;
        st.done = fin_reg;
        if (q_reg[rbp_pkg::Q_W-1])
            st.quot = neg_reg ? rbp_pkg::T_MIN : rbp_pkg::T_MAX;
        else
            st.quot = neg_reg ? -mag : mag;
    end

endmodule
